// File: rtl/pidaw_pkg.sv
// Package: shared constants, types and a saturation helper for the PID regulator.
package pidaw_pkg;

  localparam int DataW   = 32;
  localparam int AddrW   = 5;
  localparam int NumRegs = 8;

  // register indexes
  localparam logic [2:0] REG_KP  = 3'd0;
  localparam logic [2:0] REG_KI  = 3'd1;
  localparam logic [2:0] REG_KD  = 3'd2;
  localparam logic [2:0] REG_KAW = 3'd3;
  localparam logic [2:0] REG_TC  = 3'd4;
  localparam logic [2:0] REG_HI  = 3'd5;
  localparam logic [2:0] REG_LO  = 3'd6;
  localparam logic [2:0] REG_SR  = 3'd7;

  localparam logic [31:0] PeriodDefault = 32'd16777;

  typedef struct packed {
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic signed [31:0] kaw;
    logic        [31:0] tc;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic        [30:0] sr;
  } cfg_t;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    begin
      mx = 66'sd2147483647;
      mn = -66'sd2147483648;
      if (x > mx) sat32 = 32'sh7FFF_FFFF;
      else if (x < mn) sat32 = 32'sh8000_0000;
      else sat32 = x[31:0];
    end
  endfunction

endpackage

// File: rtl/pid_antiwindup_rate_limited_top.sv
// Top level: PID regulator with anti-windup, derivative filter, clamp and slew limit.
// Usage:
//  Slave stream s_axis_* carries one item per beat: tdata = {step_period, measured}
//  (measured in bits 31:0, step_period in 63:32), tuser = action (1 clears history).
//  Master stream m_axis_* returns one beat per item: tdata = drive, signed Q16.16.
//  The APB port holds gains, clamps, filter constant and slew limit at 4*index.
//  A run item waits on the serial divider for the filtered derivative (56 quotient
//  bits); its products all come from the one shared multiplier, and a zero slew
//  limit skips the slew steps. A clear item's result is valid the next cycle.
//  One item is in flight at a time; s_axis_tready is low until the result
//  beat is taken. A stalled master side holds drive stable.
//  Reset (rst, synchronous) loads register defaults, zeroes history and sets
//  the stored period to 1 ms.
module pid_antiwindup_rate_limited_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // measured, step_period
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // drive
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pidaw_pkg::cfg_t cfg;
  logic signed [31:0] drv;

  assign pready = 1'b1;

  pidaw_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
  );

  pidaw_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .action(s_axis_tuser), .measured(s_axis_tdata[31:0]),
    .step_period(s_axis_tdata[63:32]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .drive(drv)
  );

  assign m_axis_tdata = drv;

endmodule

// File: rtl/pidaw_cfg.sv
// APB register file holding gains, clamps, filter constant and slew limit.
module pidaw_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pidaw_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output pidaw_pkg::cfg_t              cfg
);

  logic wr;
  logic [2:0] idx;
  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp  <= 32'sd655360;
      cfg.ki  <= '0;
      cfg.kd  <= 32'sd65536;
      cfg.kaw <= '0;
      cfg.tc  <= 32'd335544;
      cfg.hi  <= 32'sd6553600;
      cfg.lo  <= -32'sd6553600;
      cfg.sr  <= 31'd327680000;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (idx)
        pidaw_pkg::REG_KP:  cfg.kp  <= pwdata;
        pidaw_pkg::REG_KI:  cfg.ki  <= pwdata;
        pidaw_pkg::REG_KD:  cfg.kd  <= pwdata;
        pidaw_pkg::REG_KAW: cfg.kaw <= pwdata;
        pidaw_pkg::REG_TC:  cfg.tc  <= pwdata;
        pidaw_pkg::REG_HI:  cfg.hi  <= pwdata;
        pidaw_pkg::REG_LO:  cfg.lo  <= pwdata;
        pidaw_pkg::REG_SR:  cfg.sr  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      pidaw_pkg::REG_KP:  prdata = cfg.kp;
      pidaw_pkg::REG_KI:  prdata = cfg.ki;
      pidaw_pkg::REG_KD:  prdata = cfg.kd;
      pidaw_pkg::REG_KAW: prdata = cfg.kaw;
      pidaw_pkg::REG_TC:  prdata = cfg.tc;
      pidaw_pkg::REG_HI:  prdata = cfg.hi;
      pidaw_pkg::REG_LO:  prdata = cfg.lo;
      pidaw_pkg::REG_SR:  prdata = {1'b0, cfg.sr};
      default:            prdata = '0;
    endcase
  end

endmodule

// File: rtl/pidaw_div.sv
// Restoring divider, one quotient bit a cycle, signed result truncated toward zero.
module pidaw_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic        [32:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  // dividend |num| << 24, 56 bits
  logic [55:0] dvd;
  logic [33:0] rem;
  logic [55:0] q;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic [33:0] trial;
  logic signed [65:0] sq;

  assign trial = {rem[32:0], dvd[55]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd55) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[31];
      dvd <= {(num[31] ? 32'(-num) : 32'(num)), 24'd0};
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      dvd <= {dvd[54:0], 1'b0};
      if (!trial[33]) begin
        rem <= trial;
        q   <= {q[54:0], 1'b1};
      end else begin
        rem <= {rem[32:0], dvd[55]};
        q   <= {q[54:0], 1'b0};
      end
    end
  end

  assign sq   = neg ? -$signed({10'd0, q}) : $signed({10'd0, q});
  assign quot = pidaw_pkg::sat32(sq);

endmodule

// File: rtl/pidaw_core.sv
// Sequencer around one shared multiplier and a serial divider.
module pidaw_core (
  input  logic               clk,
  input  logic               rst,
  input  pidaw_pkg::cfg_t    cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] measured,
  input  logic        [31:0] step_period,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_MI1 = 5'd1,  S_MI2 = 5'd2,  S_MA1 = 5'd3,
                         S_MA2 = 5'd4,  S_MTC = 5'd5,  S_DIVW = 5'd6, S_MP = 5'd7,
                         S_MD  = 5'd8,  S_CMD = 5'd9,  S_CLP = 5'd10, S_MSR = 5'd11,
                         S_SLW = 5'd12, S_OUT = 5'd13, S_DIVS = 5'd14,
                         S_MI1W = 5'd15, S_MA1W = 5'd16;

  logic [4:0] state;
  logic signed [31:0] integ_acc, last_error, last_deriv, last_drive, last_raw;
  logic [31:0] last_period, dt;
  logic signed [31:0] err, t0, pterm, cmd;
  logic signed [63:0] prod;     // registered product
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic [4:0] mshift;
  logic signed [65:0] mfull;
  logic signed [65:0] tcfloor;
  logic div_start, div_done;
  logic signed [31:0] num, quot;
  logic signed [39:0] delta;
  logic signed [40:0] hi, lo;

  // shared multiplier operand select
  always_comb begin
    ma = '0; mb = '0; mshift = 5'd16;
    case (state)
      S_MI1: begin ma = 33'(cfg.ki);  mb = 33'(err); end
      S_MI2: begin ma = 33'(t0); mb = {1'b0, dt}; mshift = 5'd24; end
      S_MA1: begin
        ma = 33'(cfg.kaw);
        mb = 33'(pidaw_pkg::sat32(66'(last_drive) - 66'(last_raw)));
      end
      S_MA2: begin ma = 33'(t0); mb = {1'b0, dt}; mshift = 5'd24; end
      S_MTC: begin ma = 33'(last_deriv); mb = {1'b0, cfg.tc}; mshift = 5'd24; end
      S_MP:  begin ma = 33'(cfg.kp); mb = 33'(err); end
      S_MD:  begin ma = 33'(cfg.kd); mb = 33'(quot); end
      S_MSR: begin ma = {2'b0, cfg.sr}; mb = {1'b0, dt}; mshift = 5'd24; end
      default: ;
    endcase
  end

  assign mfull = 66'(ma * mb);
  assign tcfloor = $signed(prod) >>> 24;

  assign num = pidaw_pkg::sat32(66'(pidaw_pkg::sat32(66'(err) - 66'(last_error)))
                                + 66'(pidaw_pkg::sat32(tcfloor)));

  pidaw_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num),
    .den({1'b0, dt} + {1'b0, cfg.tc}), .done(div_done), .quot(quot)
  );

  assign div_start = (state == S_DIVS);
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  // slew step bound is exact, up to 39 bits
  assign delta = 40'(prod >>> 24);
  assign hi = 41'(last_drive) + 41'(delta);
  assign lo = 41'(last_drive) - 41'(delta);

  logic [4:0] mshift_q;
  always_ff @(posedge clk) mshift_q <= mshift;
  logic signed [65:0] sh_q;
  assign sh_q = (mshift_q == 5'd24) ? (66'(prod) >>> 24) : (66'(prod) >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      integ_acc <= '0; last_error <= '0; last_deriv <= '0;
      last_drive <= '0; last_raw <= '0; last_period <= pidaw_pkg::PeriodDefault;
    end else begin
      prod <= mfull[63:0];
      case (state)
        S_IDLE: if (in_valid) begin
          if (action) begin
            integ_acc <= '0; last_error <= '0; last_deriv <= '0;
            last_drive <= '0; last_raw <= '0; drive <= '0;
            state <= S_OUT;
          end else begin
            dt  <= (step_period == '0) ? last_period : step_period;
            last_period <= (step_period == '0) ? last_period : step_period;
            err <= pidaw_pkg::sat32(-66'(measured));
            state <= S_MI1;
          end
        end
        S_MI1: state <= S_MI1W;
        // inner integral product, then scale by the period
        S_MI1W: begin t0 <= pidaw_pkg::sat32(sh_q); state <= S_MI2; end
        S_MI2: state <= S_MA1;
        S_MA1: begin
          integ_acc <= pidaw_pkg::sat32(66'(integ_acc) + 66'(pidaw_pkg::sat32(sh_q)));
          state <= S_MA1W;
        end
        // back-calculation term
        S_MA1W: begin t0 <= pidaw_pkg::sat32(sh_q); state <= S_MA2; end
        S_MA2: state <= S_MTC;
        S_MTC: begin
          integ_acc <= pidaw_pkg::sat32(66'(integ_acc) + 66'(pidaw_pkg::sat32(sh_q)));
          state <= S_DIVS;
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: if (div_done) begin
          last_error <= err; last_deriv <= quot; state <= S_MP;
        end
        S_MP: state <= S_MD;
        S_MD: begin pterm <= pidaw_pkg::sat32(sh_q); state <= S_CMD; end
        S_CMD: begin
          cmd <= pidaw_pkg::sat32(66'(pidaw_pkg::sat32(66'(pterm) + 66'(integ_acc)))
                                  + 66'(pidaw_pkg::sat32(sh_q)));
          state <= S_CLP;
        end
        S_CLP: begin
          last_raw <= cmd;
          if (cmd > cfg.hi) drive <= cfg.hi;
          else if (cmd < cfg.lo) drive <= cfg.lo;
          else drive <= cmd;
          state <= (cfg.sr != '0) ? S_MSR : S_OUT;
          if (cfg.sr == '0) last_drive <= (cmd > cfg.hi) ? cfg.hi :
                                         (cmd < cfg.lo) ? cfg.lo : cmd;
        end
        S_MSR: state <= S_SLW;
        S_SLW: begin
          if (41'(drive) > hi) begin drive <= hi[31:0]; last_drive <= hi[31:0]; end
          else if (41'(drive) < lo) begin drive <= lo[31:0]; last_drive <= lo[31:0]; end
          else last_drive <= drive;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_period: assert property (@(posedge clk) disable iff (rst) last_period != '0)
    else $error("stored period is zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive))
    else $error("result changed while stalled");
`endif

endmodule

// File: tb/tb_pid_antiwindup_rate_limited_top.sv
// PID regulator testbench: random and directed traffic checked against a cycle-free predictor.
`timescale 1ns / 100ps

module tb_pid_antiwindup_rate_limited_top;

  localparam logic ActRun   = 1'b0;
  localparam logic ActClear = 1'b1;
  localparam int   WatchdogLimit = 20000;

  typedef struct packed {
    logic        action;
    logic [31:0] period;
    logic [31:0] measured;
  } pid_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // measured, step_period
  logic        s_axis_tuser = 1'b0; // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // drive
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pid_antiwindup_rate_limited_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and history
  logic signed [31:0] m_kp, m_ki, m_kd, m_kaw, m_hi, m_lo;
  logic        [31:0] m_tc;
  logic        [30:0] m_sr;
  logic signed [31:0] m_integ, m_err, m_der, m_drive, m_raw;
  logic        [31:0] m_period;

  pid_beat_t   stim_q[$];
  logic [31:0] drive_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          timed_out = 0;

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // >>> on longint floors toward minus infinity
  function automatic logic signed [31:0] qmul(input longint a, input longint b, input int n);
    return clip32((a * b) >>> n);
  endfunction

  function automatic void predictor_reset();
    m_kp = 655360; m_ki = 0; m_kd = 65536; m_kaw = 0; m_tc = 335544;
    m_hi = 6553600; m_lo = -6553600; m_sr = 31'd327680000;
    m_integ = 0; m_err = 0; m_der = 0; m_drive = 0; m_raw = 0;
    m_period = pidaw_pkg::PeriodDefault;
  endfunction

  function automatic logic [31:0] predict_drive(input pid_beat_t b);
    logic [31:0] dt;
    logic signed [31:0] e, awd, ii, iaw, num, d, c, dr;
    longint tct, den, dl, hi, lo;
    if (b.action == ActClear) begin
      m_integ = 0; m_err = 0; m_der = 0; m_drive = 0; m_raw = 0;
      return 32'd0;
    end
    dt = (b.period == 0) ? m_period : b.period;
    m_period = dt;
    e = clip32(-longint'($signed(b.measured)));
    ii = qmul(qmul(m_ki, e, 16), longint'(dt), 24);
    awd = clip32(longint'(m_drive) - longint'(m_raw));
    iaw = qmul(qmul(m_kaw, awd, 16), longint'(dt), 24);
    m_integ = clip32(longint'(clip32(longint'(m_integ) + ii)) + iaw);
    tct = (longint'(m_tc) * longint'(m_der)) >>> 24;
    num = clip32(longint'(clip32(longint'(e) - longint'(m_err))) + longint'(clip32(tct)));
    den = longint'(dt) + longint'(m_tc);
    d = clip32((longint'(num) * 64'sd16777216) / den);
    m_err = e;
    m_der = d;
    c = clip32(longint'(qmul(m_kp, e, 16)) + longint'(m_integ));
    c = clip32(longint'(c) + longint'(qmul(m_kd, d, 16)));
    m_raw = c;
    if (c > m_hi) dr = m_hi;
    else if (c < m_lo) dr = m_lo;
    else dr = c;
    if (m_sr != 0) begin
      dl = (longint'(m_sr) * longint'(dt)) >>> 24;
      hi = longint'(m_drive) + dl;
      lo = longint'(m_drive) - dl;
      if (longint'(dr) > hi) dr = hi[31:0];
      else if (longint'(dr) < lo) dr = lo[31:0];
    end
    m_drive = dr;
    return dr;
  endfunction

  // acceptance flag seen by the driver at the next falling edge
  logic s_axis_tready_seen = 1'b0;

  // driver: bursts with random gaps; prediction made at acceptance
  int gap_left = 0, burst_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready_seen) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {stim_q[0].period, stim_q[0].measured};
          s_axis_tuser  <= stim_q[0].action;
          void'(stim_q.pop_front());
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) gap_left = $urandom_range(0, 90);
          end else burst_left--;
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready)
      drive_q.push_back(predict_drive(pid_beat_t'({s_axis_tuser, s_axis_tdata})));
  end

  // receiver stall pattern: alternating runs of ready and not ready
  int stall_run = 0;
  bit stall_on = 0;
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_on = !stall_on;
      stall_run = stall_on ? $urandom_range(0, 40) : $urandom_range(1, 60);
    end else stall_run--;
    m_axis_tready <= !stall_on;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected drive beat %h", m_axis_tdata);
        end else begin
          if (m_axis_tdata !== drive_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("drive mismatch: expected %h got %h", drive_q[0], m_axis_tdata);
          end
          void'(drive_q.pop_front());
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (!s_axis_tvalid && drive_q.size() == 0)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) timed_out = 1;
    end
  end

  function automatic logic [31:0] rand_period();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return 32'd1;
      3: return $urandom();
      default: return $urandom_range(1000, 400000);
    endcase
  endfunction

  function automatic logic [31:0] rand_meas();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return $urandom();
      default: return $urandom_range(0, 2000000) - 1000000;
    endcase
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      pidaw_pkg::REG_KP:  m_kp = val;
      pidaw_pkg::REG_KI:  m_ki = val;
      pidaw_pkg::REG_KD:  m_kd = val;
      pidaw_pkg::REG_KAW: m_kaw = val;
      pidaw_pkg::REG_TC:  m_tc = val;
      pidaw_pkg::REG_HI:  m_hi = val;
      pidaw_pkg::REG_LO:  m_lo = val;
      pidaw_pkg::REG_SR:  m_sr = val[30:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while ((stim_q.size() > 0 || s_axis_tvalid || drive_q.size() > 0) && !timed_out)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic push(input logic a, input logic [31:0] m, input logic [31:0] p);
    pid_beat_t b;
    b.action = a; b.measured = m; b.period = p;
    stim_q.push_back(b);
  endtask

  // one configuration setting per phase, extremes in some
  task automatic load_setting(input int ph);
    if (ph == 1) begin
      apb_write(pidaw_pkg::REG_KP, 32'h80000000); apb_write(pidaw_pkg::REG_KI, 32'h7FFFFFFF);
      apb_write(pidaw_pkg::REG_KD, 32'h7FFFFFFF); apb_write(pidaw_pkg::REG_KAW, 32'h80000000);
      apb_write(pidaw_pkg::REG_TC, 32'hFFFFFFFF); apb_write(pidaw_pkg::REG_HI, 32'h7FFFFFFF);
      apb_write(pidaw_pkg::REG_LO, 32'h80000000); apb_write(pidaw_pkg::REG_SR, 32'h7FFFFFFF);
    end else if (ph == 2) begin
      apb_write(pidaw_pkg::REG_KP, 32'h7FFFFFFF); apb_write(pidaw_pkg::REG_KI, 32'h80000000);
      apb_write(pidaw_pkg::REG_KD, 32'h80000000); apb_write(pidaw_pkg::REG_KAW, 32'h7FFFFFFF);
      apb_write(pidaw_pkg::REG_TC, 32'd0);        apb_write(pidaw_pkg::REG_HI, -32'sd655360);
      apb_write(pidaw_pkg::REG_LO, 32'sd655360);  apb_write(pidaw_pkg::REG_SR, 32'd0);
    end else begin
      apb_write(pidaw_pkg::REG_KP, $urandom_range(0, 2000000) - 1000000);
      apb_write(pidaw_pkg::REG_KI, $urandom_range(0, 20000000) - 10000000);
      apb_write(pidaw_pkg::REG_KD, $urandom_range(0, 200000) - 100000);
      apb_write(pidaw_pkg::REG_KAW, $urandom_range(0, 20000000));
      apb_write(pidaw_pkg::REG_TC,
                ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 2000000));
      apb_write(pidaw_pkg::REG_HI, $urandom_range(0, 10000000));
      apb_write(pidaw_pkg::REG_LO, -$urandom_range(0, 10000000));
      apb_write(pidaw_pkg::REG_SR,
                ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400000000));
    end
  endtask

  initial begin
    predictor_reset();
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    // directed: field extremes, clear, zero period, saturated negation
    push(ActRun, 32'd65536, 32'd0);
    push(ActRun, 32'h80000000, 32'd16777);
    push(ActRun, 32'h7FFFFFFF, 32'hFFFFFFFF);
    push(ActRun, 32'd0, 32'd1);
    push(ActClear, 32'hFFFFFFFF, 32'hFFFFFFFF);
    push(ActRun, 32'hFFFF0000, 32'd0);
    push(ActRun, 32'h80000000, 32'd0);
    push(ActClear, 32'd0, 32'd0);
    push(ActRun, 32'h00010000, 32'd335544);
    drain();
    for (int ph = 1; ph <= 8 && !timed_out; ph++) begin
      load_setting(ph);
      push(ActRun, 32'h80000000, 32'hFFFFFFFF);
      push(ActRun, 32'h7FFFFFFF, 32'd0);
      for (int i = 0; i < 235; i++)
        push(($urandom_range(0, 19) == 0) ? ActClear : ActRun, rand_meas(), rand_period());
      drain();
    end
    if (!timed_out && mismatches == 0) $display("[pid_antiwindup_rate_limited_top] OK");
    else $display("[pid_antiwindup_rate_limited_top] ERROR");
    $finish;
  end

endmodule
